### rtl/core/lpht_pkg.sv
// Package for the linear probing hash table: types, codes and constants.
// Used by linear_probe_hash_table and lpht_hash; depends on nothing.
`default_nettype none
package lpht_pkg;

  localparam int unsigned SLOTS_DEF     = 256;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam logic [31:0] HASH_START    = 32'd5381;
  localparam int unsigned HASH_SHIFT    = 5;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_CLEAR,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/core/linear_probe_hash_table.sv
// Top level of the linear probing hash table with djb2 hashing.
// Depends on lpht_pkg, lpht_hash and lpht_ram.
//
//   channel   direction  tdata fields (low bit up)
//   s_axis    in         opcode, key_bytes, key_length, new_value (pad to 104)
//   m_axis    out        status, found_value (pad to 40)
//
// An item is taken in, then hashed one key byte per cycle, then its home slot
// is formed; each probed slot is a memory read, then a compare; the result
// then stays on the output until it is taken. An OP_NONE item skips the probe.
// When SLOTS is not a power of two, the home slot is reduced modulo SLOTS by
// compare and subtract steps. After reset a clearing pass writes every mark to
// empty, one slot a cycle; input is not ready during it, while an item is in
// work or while its result waits on the output.
`default_nettype none
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned KEY_BYTES = KEY_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[1:0], key_bytes[65:2], key_length[69:66], new_value[101:70]
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], found_value[33:2]
  output logic      [39:0]  m_axis_tdata
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = 2 + 64 + 4 + 32 + 32;
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [31:0] MSUB_TOP = 32'(SLOTS) << (32 - AW);

  state_t state, state_next;
  op_t op;
  logic [63:0] key;
  logic [3:0] len;
  logic [31:0] nval;
  logic [3:0] bcnt;
  logic [AW-1:0] idx;
  logic [CW-1:0] pcnt;
  logic [1:0] status;
  logic [31:0] fval;
  logic [31:0] hash;
  logic [31:0] rem, rem_next, msub;
  logic [3:0] len_in;
  logic [63:0] key_in;
  logic [63:0] mask_in;
  logic hstart, hstep;
  logic we;
  logic [EW-1:0] wdata, rdata;
  logic [1:0] r_mark;
  logic [63:0] r_key;
  logic [3:0] r_len;
  logic [31:0] r_hash, r_val;
  logic match, last;

  always_comb begin
    len_in = s_axis_tdata[69:66];
    if (len_in > 4'(KEY_BYTES)) begin
      len_in = 4'(KEY_BYTES);
    end
    mask_in = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(len_in)) begin
        mask_in[i*8 +: 8] = 8'hFF;
      end
    end
    key_in = s_axis_tdata[65:2] & mask_in;
  end

  assign hstart = (state == S_IDLE);
  assign hstep  = (state == S_HASH) && (bcnt < len);

  lpht_hash u_hash (
    .clk  (clk),
    .start(hstart),
    .step (hstep),
    .data (key[bcnt[2:0]*8 +: 8]),
    .hash (hash)
  );

  assign rem_next = (rem >= msub) ? rem - msub : rem;

  assign {r_val, r_hash, r_len, r_key, r_mark} = rdata;
  assign match = (r_mark == MARK_USED) && (r_hash == hash) && (r_len == len)
                 && (r_key == key);
  assign last = (pcnt == CW'(SLOTS - 1));

  always_comb begin
    we = 1'b0;
    wdata = rdata;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wdata = '0;
    end else if (state == S_CHECK) begin
      if (op == OP_PUT && r_mark != MARK_USED) begin
        we = 1'b1;
        wdata = {nval, hash, len, key, MARK_USED};
      end else if (op == OP_REMOVE && match) begin
        we = 1'b1;
        wdata[1:0] = MARK_DELETED;
      end
    end
  end

  lpht_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (idx),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (idx == AW'(SLOTS - 1)) state_next = S_IDLE;
      S_IDLE:  if (s_axis_tvalid) state_next = S_HASH;
      S_HASH: begin
        if (bcnt >= len) begin
          state_next = (op == OP_NONE) ? S_DONE : (POW2 ? S_READ : S_MOD);
        end
      end
      S_MOD:   if (msub == 32'(SLOTS)) state_next = S_READ;
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        if (op == OP_PUT) begin
          state_next = (r_mark != MARK_USED || last) ? S_DONE : S_READ;
        end else begin
          state_next = (match || r_mark == MARK_EMPTY || last) ? S_DONE : S_READ;
        end
      end
      S_DONE:  if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_DONE);
    m_axis_tdata  = {6'd0, fval, status};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: idx <= idx + AW'(1);
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op     <= op_t'(s_axis_tdata[1:0]);
            key    <= key_in;
            len    <= len_in;
            nval   <= s_axis_tdata[101:70];
            bcnt   <= '0;
            status <= ST_MISSING;
            fval   <= '0;
          end
        end
        S_HASH: begin
          if (bcnt < len) begin
            bcnt <= bcnt + 4'd1;
          end else begin
            idx  <= hash[AW-1:0];
            rem  <= hash;
            msub <= MSUB_TOP;
            pcnt <= '0;
          end
        end
        S_MOD: begin
          rem  <= rem_next;
          msub <= msub >> 1;
          idx  <= rem_next[AW-1:0];
        end
        S_CHECK: begin
          if (op == OP_PUT) begin
            if (r_mark != MARK_USED) status <= ST_OK;
            else if (last) status <= ST_FULL;
          end else if (match) begin
            status <= ST_OK;
            fval   <= r_val;
          end
          idx  <= (idx == AW'(SLOTS - 1)) ? '0 : idx + AW'(1);
          pcnt <= pcnt + CW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/lpht_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
`default_nettype none
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### rtl/core/lpht_hash.sv
// djb2 unit: one key byte per cycle while step is high, through a shift and add.
// Depends on lpht_pkg.
`default_nettype none
module lpht_hash
  import lpht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        start,
  input  wire logic        step,
  input  wire logic [7:0]  data,
  output logic      [31:0] hash
);

  logic [31:0] hash_next;

  always_comb begin
    hash_next = (hash << HASH_SHIFT) + hash + {24'd0, data};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash <= HASH_START;
    end else if (step) begin
      hash <= hash_next;
    end
  end

endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking testbench for linear_probe_hash_table: directed table, then random
// put/get/remove (and rare no-op) traffic checked against a behavioral model of the table.
// Depends on lpht_pkg and the RTL in rtl/core.
`default_nettype none
module tb
  import lpht_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 256;
  localparam int NRAND = 600;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  len;
    logic [63:0] key;
    op_t         op;
  } req_t;

  typedef struct {
    req_t        r;
    logic        fixed;
    status_t     st;
    logic [31:0] val;
  } row_t;

  typedef struct {
    status_t     st;
    logic [31:0] val;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  linear_probe_hash_table dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mark_t       mark_q[NSLOT];
  logic [63:0] key_q[NSLOT];
  logic [3:0]  len_q[NSLOT];
  logic [31:0] hash_q[NSLOT];
  logic [31:0] value_q[NSLOT];

  answer_t answers[$];
  int mismatches = 0;
  bit sending_done = 0;
  bit hold_off = 0;
  bit calm = 0;
  longint cycles = 0;
  logic [63:0] pool[8];
  logic [3:0] pool_len[8];

  function automatic logic [31:0] djb2(logic [63:0] k, int n);
    logic [31:0] h;
    h = 32'd5381;
    for (int i = 0; i < n; i++) h = (h << 5) + h + {24'd0, k[8*i +: 8]};
    return h;
  endfunction

  function automatic answer_t table_step(req_t r);
    answer_t a;
    int n;
    logic [63:0] k;
    logic [31:0] h;
    int idx;
    a.st = ST_MISSING;
    a.val = '0;
    n = (r.len > 8) ? 8 : r.len;
    k = (n == 8) ? r.key : r.key & ((64'd1 << (8 * n)) - 1);
    h = djb2(k, n);
    if (r.op == OP_PUT) begin
      a.st = ST_FULL;
      for (int i = 0; i < NSLOT; i++) begin
        idx = (h % NSLOT + i) % NSLOT;
        if (mark_q[idx] != MARK_USED) begin
          mark_q[idx] = MARK_USED;
          key_q[idx] = k;
          len_q[idx] = n[3:0];
          hash_q[idx] = h;
          value_q[idx] = r.value;
          a.st = ST_OK;
          break;
        end
      end
    end else if (r.op == OP_GET || r.op == OP_REMOVE) begin
      for (int i = 0; i < NSLOT; i++) begin
        idx = (h % NSLOT + i) % NSLOT;
        if (mark_q[idx] == MARK_EMPTY) break;
        if (mark_q[idx] == MARK_USED && hash_q[idx] == h && len_q[idx] == n &&
            key_q[idx] == k) begin
          a.st = ST_OK;
          a.val = value_q[idx];
          if (r.op == OP_REMOVE) mark_q[idx] = MARK_DELETED;
          break;
        end
      end
    end
    return a;
  endfunction

  task automatic send_item(req_t r, logic fixed, status_t st, logic [31:0] val);
    answer_t a;
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    a = table_step(r);
    if (fixed && (a.st != st || a.val != val)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with model: %0d/%h vs %0d/%h", st, val, a.st, a.val);
    end
    answers.push_back(a);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic req_t rand_req(int fill);
    req_t r;
    int p;
    int sel;
    r.value = $urandom;
    sel = $urandom_range(99);
    r.op = (sel < fill) ? OP_PUT : (sel < fill + (100 - fill) * 2 / 3) ? OP_GET : OP_REMOVE;
    if ($urandom_range(199) == 0) r.op = OP_NONE;
    p = $urandom_range(7);
    r.key = pool[p];
    r.len = pool_len[p];
    if ($urandom_range(9) == 0) begin
      r.key = {$urandom, $urandom};
      r.len = 4'($urandom_range(15));
    end else if ($urandom_range(4) == 0) begin
      r.key = r.key ^ ({$urandom, $urandom} << (8 * r.len));
      if (r.len == 8 && $urandom_range(1)) r.len = 4'($urandom_range(15, 9));
    end
    return r;
  endfunction

  initial begin
    row_t rows[$];
    req_t r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    rows.push_back('{'{32'h0, 4'd3, 64'h636261, OP_GET}, 1, ST_MISSING, 32'h0});
    rows.push_back('{'{32'h0, 4'd3, 64'h636261, OP_REMOVE}, 1, ST_MISSING, 32'h0});
    rows.push_back('{'{32'hFFFFFFFF, 4'd0, 64'hFFFFFFFFFFFFFFFF, OP_PUT}, 1, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd0, 64'h0, OP_GET}, 1, ST_OK, 32'hFFFFFFFF});
    rows.push_back('{'{32'h0, 4'd0, 64'h0, OP_NONE}, 1, ST_MISSING, 32'h0});
    rows.push_back('{'{32'h12345678, 4'd8, 64'hFFFFFFFFFFFFFFFF, OP_PUT}, 1, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd15, 64'hFFFFFFFFFFFFFFFF, OP_GET}, 1, ST_OK, 32'h12345678});
    rows.push_back('{'{32'h0, 4'd7, 64'hFFFFFFFFFFFFFFFF, OP_GET}, 1, ST_MISSING, 32'h0});
    rows.push_back('{'{32'hA5A5A5A5, 4'd2, 64'hDEAD0000_00006162, OP_PUT}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h5A5A5A5A, 4'd2, 64'h6162, OP_PUT}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd2, 64'h6162, OP_GET}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd2, 64'hFF6162, OP_REMOVE}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd2, 64'h6162, OP_GET}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd2, 64'h6162, OP_REMOVE}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd2, 64'h6162, OP_GET}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h77, 4'd2, 64'h6162, OP_PUT}, 0, ST_OK, 32'h0});
    rows.push_back('{'{32'h0, 4'd0, 64'h0, OP_REMOVE}, 1, ST_OK, 32'hFFFFFFFF});
    rows.push_back('{'{32'h0, 4'd0, 64'h0, OP_GET}, 1, ST_MISSING, 32'h0});
    foreach (rows[i]) send_item(rows[i].r, rows[i].fixed, rows[i].st, rows[i].val);

    for (int i = 0; i < 8; i++) begin
      pool[i] = {$urandom, $urandom};
      pool_len[i] = 4'($urandom_range(8));
    end
    // Mostly puts first so the table fills and reports full, then drains.
    for (int i = 0; i < NRAND; i++) begin
      if (i % 50 == 0)
        for (int j = 0; j < 8; j++) begin
          pool[j] = {$urandom, $urandom};
          pool_len[j] = 4'($urandom_range(8));
        end
      calm = (i >= 150 && i < 250);
      if (i == 100) hold_off = 1;
      r = rand_req(i < 350 ? 80 : 20);
      send_item(r, 0, ST_OK, 32'h0);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1;
  end

  // Receiver ready: random drops, always high while calm, and one long hold-off while the sender keeps offering items.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold = 0;
        while (hold < 400) begin
          m_axis_tready <= 1'b0;
          @(posedge clk);
          hold++;
        end
        hold_off = 0;
      end else m_axis_tready <= calm || $urandom_range(99) >= 6;
    end
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %h", m_axis_tdata);
      end else begin
        a = answers.pop_front();
        if (m_axis_tdata[1:0] != a.st || m_axis_tdata[33:2] != a.val) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d value %h, got status %0d value %h",
                     a.st, a.val, m_axis_tdata[1:0], m_axis_tdata[33:2]);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (sending_done && answers.size() == 0) begin
        repeat (1200) @(posedge clk);
        if (mismatches == 0 && answers.size() == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
